// ===== sv/prac_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the point rotator.
package prac_pkg;

  localparam int COORD_W   = 32;
  localparam int ANGLE_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int QUAD_W    = 2;
  localparam int MAX_STEPS = 32;
  localparam int CFG_IDX_W = 2;

  // Queue depth between front and back; must be a power of two
  localparam int QUEUE_DEPTH = 2;

  // CORDIC limit gain 1/An, scaled by 2^30
  localparam longint GAIN_Q30 = 64'sd652032875;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1
  } cfg_reg_e;

  typedef enum logic [QUAD_W-1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  typedef struct packed {
    logic        [ANGLE_W-1:0] angle;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    quad_e                     quad;
    logic signed [ANGLE_W-1:0] resid;
  } work_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ANGLE_W-1:0] atan_turn(input int unsigned idx);
    logic signed [ANGLE_W-1:0] a;
    unique case (idx)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      24:      a = 32'h0000_0029;
      25:      a = 32'h0000_0014;
      26:      a = 32'h0000_000A;
      27:      a = 32'h0000_0005;
      28:      a = 32'h0000_0003;
      29:      a = 32'h0000_0001;
      30:      a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/prac_stream_if.sv =====
// Valid/ready stream channel carrying one item per handshake.
interface prac_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/prac_front.sv =====
// Front end: accept input items, form offsets from the centre and fold the angle.
module prac_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [prac_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [prac_pkg::COORD_W-1:0] center_y_i,
  prac_stream_if.sink                    in_if,
  prac_stream_if.source                  work_if
);
  import prac_pkg::*;

  logic [ANGLE_W-1:0] shifted;
  work_t              work_d, work_q;
  logic               valid_q;
  logic               take;

  // Accept whenever the holding register is empty or being drained
  assign in_if.ready = !valid_q || work_if.ready;
  assign take        = in_if.valid && in_if.ready;

  // Classify: quadrant, signed residual angle and exact 33-bit offsets
  always_comb begin
    shifted      = in_if.payload.angle + ANGLE_W'(32'h2000_0000);
    work_d.quad  = quad_e'(shifted[ANGLE_W-1 -: QUAD_W]);
    work_d.resid = in_if.payload.angle - {shifted[ANGLE_W-1 -: QUAD_W], {(ANGLE_W-QUAD_W){1'b0}}};
    work_d.dx    = DIFF_W'(in_if.payload.point_x) - DIFF_W'(center_x_i);
    work_d.dy    = DIFF_W'(in_if.payload.point_y) - DIFF_W'(center_y_i);
  end

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (work_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      work_q <= work_d;
    end
  end

  assign work_if.valid   = valid_q;
  assign work_if.payload = work_q;

endmodule

// ===== sv/prac_queue.sv =====
// Short queue of classified items between the front and the back end.
module prac_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  prac_stream_if.sink   push_if,
  prac_stream_if.source pop_if
);
  import prac_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  work_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             push, pop;

  assign push_if.ready  = (cnt_q != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_if.valid   = (cnt_q != '0);
  assign pop_if.payload = mem_q[rd_q];

  assign push = push_if.valid && push_if.ready;
  assign pop  = pop_if.valid && pop_if.ready;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (PTR_W+1)'(1);
      end
    end
  end

  // Store the incoming item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_if.payload;
    end
  end

endmodule

// ===== sv/prac_back.sv =====
// Back end: pipelined CORDIC, quadrant unfold, rotation products, rounding and saturation.
module prac_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [prac_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [prac_pkg::COORD_W-1:0] center_y_i,
  prac_stream_if.sink                        work_if,
  prac_stream_if.source                      out_if
);
  import prac_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int VW    = FRAC_BITS + 3;
  localparam int PW    = DIFF_W + VW;
  localparam int SW    = PW + 1;
  localparam int RW    = SW + 1;

  localparam longint X0_L = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam logic signed [VW-1:0] X0      = VW'(X0_L);
  localparam logic signed [SW-1:0] HALF    = SW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [RW-1:0] SAT_HI  = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] SAT_LO  = RW'(-64'sd2147483648);

  typedef struct packed {
    logic signed [VW-1:0]      x;
    logic signed [VW-1:0]      y;
    logic signed [ANGLE_W-1:0] z;
    quad_e                     quad;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
  } rot_t;

  typedef struct packed {
    logic signed [PW-1:0] xc;
    logic signed [PW-1:0] ys;
    logic signed [PW-1:0] xs;
    logic signed [PW-1:0] yc;
  } prod_t;

  rot_t                     stg_q [STEPS+1];
  logic [STEPS:0]           stg_vld_q;
  prod_t                    prd_d, prd_q;
  logic                     prd_vld_q;
  logic signed [SW-1:0]     tx_d, ty_d, tx_q, ty_q;
  logic                     sum_vld_q;
  logic signed [VW-1:0]     cs, sn;
  logic signed [RW-1:0]     fx, fy;
  out_item_t                out_q;
  logic                     out_vld_q;
  logic                     adv;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RW-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Whole pipeline moves unless a finished result waits at the output
  assign adv           = !out_vld_q || out_if.ready;
  assign work_if.ready = adv;

  // Advance valid bits through every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
      prd_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      stg_vld_q <= {stg_vld_q[STEPS-1:0], work_if.valid};
      prd_vld_q <= stg_vld_q[STEPS];
      sum_vld_q <= prd_vld_q;
      out_vld_q <= sum_vld_q;
    end
  end

  // Load the start vector, pre-scaled by the gain compensation
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0].x    <= X0;
      stg_q[0].y    <= '0;
      stg_q[0].z    <= work_if.payload.resid;
      stg_q[0].quad <= work_if.payload.quad;
      stg_q[0].dx   <= work_if.payload.dx;
      stg_q[0].dy   <= work_if.payload.dy;
    end
  end

  // One micro-rotation per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic signed [ANGLE_W-1:0] ATAN = atan_turn(k);
    rot_t nxt;

    always_comb begin
      nxt = stg_q[k];
      if (!stg_q[k].z[ANGLE_W-1]) begin
        nxt.x = stg_q[k].x - (stg_q[k].y >>> k);
        nxt.y = stg_q[k].y + (stg_q[k].x >>> k);
        nxt.z = stg_q[k].z - ATAN;
      end else begin
        nxt.x = stg_q[k].x + (stg_q[k].y >>> k);
        nxt.y = stg_q[k].y - (stg_q[k].x >>> k);
        nxt.z = stg_q[k].z + ATAN;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[k+1] <= nxt;
      end
    end
  end

  // Unfold the quadrant into cosine and sine
  always_comb begin
    unique case (stg_q[STEPS].quad)
      QUAD_0: begin
        cs = stg_q[STEPS].x;
        sn = stg_q[STEPS].y;
      end
      QUAD_90: begin
        cs = -stg_q[STEPS].y;
        sn = stg_q[STEPS].x;
      end
      QUAD_180: begin
        cs = -stg_q[STEPS].x;
        sn = -stg_q[STEPS].y;
      end
      default: begin
        cs = stg_q[STEPS].y;
        sn = -stg_q[STEPS].x;
      end
    endcase
  end

  // Form the four rotation products
  always_comb begin
    prd_d.xc = PW'(stg_q[STEPS].dx) * PW'(cs);
    prd_d.ys = PW'(stg_q[STEPS].dy) * PW'(sn);
    prd_d.xs = PW'(stg_q[STEPS].dx) * PW'(sn);
    prd_d.yc = PW'(stg_q[STEPS].dy) * PW'(cs);
  end

  // Sum, round half up and drop the fraction
  always_comb begin
    tx_d = (SW'(prd_q.xc) - SW'(prd_q.ys) + HALF) >>> FRAC_BITS;
    ty_d = (SW'(prd_q.xs) + SW'(prd_q.yc) + HALF) >>> FRAC_BITS;
  end

  // Add the centre back
  always_comb begin
    fx = RW'(center_x_i) + RW'(tx_q);
    fy = RW'(center_y_i) + RW'(ty_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prd_q           <= prd_d;
      tx_q            <= tx_d;
      ty_q            <= ty_d;
      out_q.rotated_x <= sat_coord(fx);
      out_q.rotated_y <= sat_coord(fy);
    end
  end

  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_q;

endmodule

// ===== sv/point_rotate_about_center.sv =====
// Top level of the point rotator: centre registers, front end, queue and back end.
//
// Rotates each point counterclockwise about the configured centre (center_x, center_y)
// by a binary angle (2^32 = one turn); coordinates are signed Q16.16, results are rounded
// half up and saturate at the 32-bit limits. The block takes one item per clock while the
// output keeps taking results, and returns one result per item, in order. From input
// acceptance to the result appearing, each item passes one front register, one queue slot,
// the start-vector register, one pipeline stage per CORDIC iteration, the product stage, the
// rounding stage and the output register. The back end stalls as a whole while a result
// waits at the output; the two-entry queue lets the front keep taking items meanwhile.
// Centre registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i (index 0 is
// center_x, 1 is center_y, others are ignored) and must only change while the block is
// empty.
module point_rotate_about_center #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [prac_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [prac_pkg::COORD_W-1:0]         cfg_wdata_i,
  prac_stream_if.sink                          in_if,
  prac_stream_if.source                        out_if
);
  import prac_pkg::*;

  logic signed [COORD_W-1:0] center_x_q, center_y_q;

  prac_stream_if #(.item_t(work_t)) front_if ();
  prac_stream_if #(.item_t(work_t)) back_if ();

  // Hold the centre registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= 32'sd65536;
      center_y_q <= 32'sd131072;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_CENTER_X) begin
        center_x_q <= cfg_wdata_i;
      end
      if (cfg_index_i == CFG_CENTER_Y) begin
        center_y_q <= cfg_wdata_i;
      end
    end
  end

  prac_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .in_if      (in_if),
    .work_if    (front_if)
  );

  prac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_if (front_if),
    .pop_if  (back_if)
  );

  prac_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .work_if    (back_if),
    .out_if     (out_if)
  );

endmodule

// ===== tb/sv/point_rotate_about_center_tb.sv =====
// Self-checking testbench for the point rotator: directed table, then random streams per centre.
module point_rotate_about_center_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prac_pkg::*;

  localparam int CORDIC_STEPS    = 16;
  localparam int FRAC_BITS       = 16;
  localparam int LATENCY         = CORDIC_STEPS + 6;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int MAX_IDLE        = 9;
  localparam int LONG_HOLD       = 300;
  localparam int PRINT_LIMIT     = 50;
  // ~1900 items at worst-case idle gaps and stalls plus full latency each, the phase
  // drains and the long hold set the watchdog limit, with margin on top
  localparam int CYCLE_LIMIT     = 400_000;

  localparam longint GAIN_K_Q30 = 64'sd652032875;
  localparam longint COORD_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam longint COORD_MIN  = 64'shFFFF_FFFF_8000_0000;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // atan(2^-i) in units of 2^-32 turn
  localparam longint ATAN_TURN [32] = '{
    'h2000_0000, 'h12E4_051E, 'h09FB_385B, 'h0511_11D4, 'h028B_0D43, 'h0145_D7E1,
    'h00A2_F61E, 'h0051_7C55, 'h0028_BE53, 'h0014_5F2F, 'h000A_2F98, 'h0005_17CC,
    'h0002_8BE6, 'h0001_45F3, 'h0000_A2FA, 'h0000_517D, 'h0000_28BE, 'h0000_145F,
    'h0000_0A30, 'h0000_0518, 'h0000_028C, 'h0000_0146, 'h0000_00A3, 'h0000_0051,
    'h0000_0029, 'h0000_0014, 'h0000_000A, 'h0000_0005, 'h0000_0003, 'h0000_0001,
    'h0000_0001, 'h0000_0000
  };

  // Centre per random phase; phase 0 keeps the reset centre, the last one is random
  localparam logic [31:0] CENTRE_X_TAB [NUM_PHASES-1] = '{
    32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000
  };
  localparam logic [31:0] CENTRE_Y_TAB [NUM_PHASES-1] = '{
    32'h0002_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF
  };

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] px;
    logic [31:0] py;
    logic        has_want;
    logic [31:0] rx;
    logic [31:0] ry;
  } directed_row_t;

  // Directed items under the reset centre (1.0, 2.0); a point on the centre stays put
  localparam directed_row_t DIRECTED_ROWS [22] = '{
    '{32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0001_0000, 32'h0002_0000},
    '{32'hFFFF_FFFF, 32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0001_0000, 32'h0002_0000},
    '{32'h4000_0000, 32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0001_0000, 32'h0002_0000},
    '{32'h8000_0000, 32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0001_0000, 32'h0002_0000},
    '{32'h0000_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    '{32'h4000_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    '{32'h8000_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    '{32'hC000_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    '{32'h1FFF_FFFF, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{32'h2000_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{32'h5FFF_FFFF, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{32'h6000_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{32'hDFFF_FFFF, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{32'hE000_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_wdata;

  prac_stream_if #(.item_t(in_item_t))  pt_if ();
  prac_stream_if #(.item_t(out_item_t)) rot_if ();

  // Own copy of the centre registers
  longint centre_x = 65536;
  longint centre_y = 131072;

  out_item_t   expected_rotations [$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int unsigned tx_max_gap     = MAX_IDLE;
  int unsigned rx_max_stall   = MAX_IDLE;
  int unsigned rx_hold_cycles = 0;

  point_rotate_about_center #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .FRAC_BITS   (FRAC_BITS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (pt_if.sink),
    .out_if     (rot_if.source)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] saturate_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX[31:0];
    if (v < COORD_MIN) return COORD_MIN[31:0];
    return v[31:0];
  endfunction

  // Rotate one point about the current centre: quadrant fold, CORDIC, round, saturate
  function automatic out_item_t rotate_about_centre(input in_item_t item);
    logic [31:0] turned;
    logic [31:0] resid;
    quad_e       quad;
    longint      z, vx, vy, sx, sy, cs, sn, dx, dy, half;
    out_item_t   res;
    turned = item.angle + 32'h2000_0000;
    quad   = quad_e'(turned[31:30]);
    resid  = item.angle - {turned[31:30], 30'd0};
    z      = longint'($signed(resid));
    vx     = (GAIN_K_Q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    vy     = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (z >= 0) begin
        vx = vx - sy;
        vy = vy + sx;
        z  = z - ATAN_TURN[i];
      end else begin
        vx = vx + sy;
        vy = vy - sx;
        z  = z + ATAN_TURN[i];
      end
    end
    // Map the residual rotation back into its quadrant
    case (quad)
      QUAD_0: begin
        cs = vx;
        sn = vy;
      end
      QUAD_90: begin
        cs = -vy;
        sn = vx;
      end
      QUAD_180: begin
        cs = -vx;
        sn = -vy;
      end
      default: begin
        cs = vy;
        sn = -vx;
      end
    endcase
    dx   = longint'($signed(item.point_x)) - centre_x;
    dy   = longint'($signed(item.point_y)) - centre_y;
    half = longint'(1) << (FRAC_BITS - 1);
    res.rotated_x = saturate_coord(centre_x + ((dx * cs - dy * sn + half) >>> FRAC_BITS));
    res.rotated_y = saturate_coord(centre_y + ((dx * sn + dy * cs + half) >>> FRAC_BITS));
    return res;
  endfunction

  // Near the centre most often, else anywhere, near the origin or at the very limits
  function automatic logic [31:0] random_coord(input longint centre);
    int unsigned sel;
    logic [31:0] c;
    sel = $urandom_range(9, 0);
    c   = centre[31:0];
    case (sel)
      0, 1, 2, 3: return c + $urandom_range(32'h000F_FFFF, 0) - 32'h0008_0000;
      4, 5, 6:    return $urandom();
      7:          return $urandom_range(1, 0) ? 32'h7FFF_FFFF - $urandom_range(15, 0)
                                              : 32'h8000_0000 + $urandom_range(15, 0);
      default:    return $urandom_range(511, 0) - 32'd256;
    endcase
  endfunction

  // Any angle, with extra weight on the quadrant fold boundaries and the quarter-turn axes
  function automatic logic [31:0] random_angle();
    logic [31:0] a;
    a = $urandom();
    case ($urandom_range(5, 0))
      0:       return {a[31:30], 30'h2000_0000} + $urandom_range(15, 0) - 32'd8;
      1:       return {a[31:30], 30'd0} + $urandom_range(3, 0) - 32'd2;
      default: return a;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t: mismatch, %s", $time, msg);
  endtask

  task automatic check_rotation(input out_item_t got);
    out_item_t want;
    if (expected_rotations.size() == 0) begin
      report_mismatch($sformatf("unexpected item x=%h y=%h", got.rotated_x, got.rotated_y));
    end else begin
      want = expected_rotations.pop_front();
      if (got.rotated_x !== want.rotated_x)
        report_mismatch($sformatf("rotated_x got %h want %h", got.rotated_x, want.rotated_x));
      if (got.rotated_y !== want.rotated_y)
        report_mismatch($sformatf("rotated_y got %h want %h", got.rotated_y, want.rotated_y));
    end
  endtask

  // Offer one point after a random gap; hold valid until it is taken
  task automatic offer_point(input in_item_t item, input out_item_t want);
    int unsigned gap;
    gap = $urandom_range(tx_max_gap, 0);
    @(negedge clk);
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pt_if.valid   <= 1'b1;
    pt_if.payload <= item;
    do @(posedge clk); while (!pt_if.ready);
    expected_rotations.push_back(want);
  endtask

  // Drop valid and wait until every expected item has come back
  task automatic drain_points();
    @(negedge clk);
    pt_if.valid <= 1'b0;
    wait (expected_rotations.size() == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CENTER_X: centre_x = longint'($signed(data));
      CFG_CENTER_Y: centre_y = longint'($signed(data));
      default: ;
    endcase
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    rot_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(rx_max_stall, 0);
      end
      @(negedge clk);
      if (stall > 0) begin
        rot_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rot_if.ready <= 1'b1;
      do @(posedge clk); while (!rot_if.valid);
      check_rotation(rot_if.payload);
    end
  end

  // Stimulus: reset, directed table, then one random stream per centre setting
  initial begin : point_source
    in_item_t    pt;
    out_item_t   want;
    logic [31:0] cx;
    logic [31:0] cy;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_CENTER_X;
    cfg_wdata     = '0;
    pt_if.valid   = 1'b0;
    pt_if.payload = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[k]) begin
      pt.angle   = DIRECTED_ROWS[k].angle;
      pt.point_x = DIRECTED_ROWS[k].px;
      pt.point_y = DIRECTED_ROWS[k].py;
      if (DIRECTED_ROWS[k].has_want) begin
        want.rotated_x = DIRECTED_ROWS[k].rx;
        want.rotated_y = DIRECTED_ROWS[k].ry;
      end else begin
        want = rotate_about_centre(pt);
      end
      offer_point(pt, want);
    end
    drain_points();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Move the centre while empty; spare indexes must leave it alone
      if (ph > 0) begin
        cx = (ph == NUM_PHASES - 1) ? $urandom() : CENTRE_X_TAB[ph];
        cy = (ph == NUM_PHASES - 1) ? $urandom() : CENTRE_Y_TAB[ph];
        write_reg(CFG_SPARE_2, $urandom());
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_SPARE_3, $urandom());
      end
      // Phase 1 runs flat out on both sides
      tx_max_gap   = (ph == 1) ? 0 : MAX_IDLE;
      rx_max_stall = (ph == 1) ? 0 : MAX_IDLE;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Long hold at the output while points keep coming: fill up and back-pressure
        if (ph == 2 && n == 40) begin
          rx_hold_cycles = LONG_HOLD;
          tx_max_gap     = 0;
        end
        if (ph == 2 && n == 140) tx_max_gap = MAX_IDLE;
        // Pause mid-stream until empty
        if (ph == 4 && n == ITEMS_PER_PHASE / 2) drain_points();
        // Alternate idle and busy stretches
        if (ph == 5) begin
          tx_max_gap   = ((n / 40) % 2 == 1) ? 0 : MAX_IDLE;
          rx_max_stall = ((n / 60) % 2 == 1) ? 0 : MAX_IDLE;
        end
        pt.angle   = random_angle();
        pt.point_x = random_coord(centre_x);
        pt.point_y = random_coord(centre_y);
        offer_point(pt, rotate_about_centre(pt));
      end
      drain_points();
    end

    // Catch any stray items after the last one
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
